>>> hdl/assert_macros.svh
// Assertion macros for the checker file of the timer block.
// Each macro expands to one labeled concurrent assertion with async reset disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define DRT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define DRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> hdl/drt_pkg.sv
// Shared constants, register map and item types of the dual reload timer block.
// Used by drt_front, drt_core and the top level; depends on nothing.
package drt_pkg;

    localparam int PRESCALE_DIVISOR = 20;

    localparam int CLK_W  = 16;
    localparam int CMD_W  = 2;
    localparam int ADDR_W = 6;
    localparam int DATA_W = 8;
    localparam int CNT_W  = 16;
    localparam int FREE_W = 8;

    // The remainder may rest at exactly the divisor, so it needs one extra code.
    localparam int REM_W = $clog2(PRESCALE_DIVISOR + 1);

    // Reciprocal for the constant divide: exact for every CLK_W-bit dividend.
    localparam int DIV_SHIFT = CLK_W + $clog2(PRESCALE_DIVISOR) + 1;
    localparam longint unsigned DIV_MULT_FULL =
        ((64'd1 << DIV_SHIFT) + PRESCALE_DIVISOR - 1) / PRESCALE_DIVISOR;
    localparam logic [DIV_SHIFT-1:0] DIV_MULT = DIV_SHIFT'(DIV_MULT_FULL);

    localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

    localparam logic [ADDR_W-1:0] ADDR_CNT0_LO = 6'h0C;
    localparam logic [ADDR_W-1:0] ADDR_CNT0_HI = 6'h0D;
    localparam logic [ADDR_W-1:0] ADDR_RLD0_LO = 6'h0E;
    localparam logic [ADDR_W-1:0] ADDR_RLD0_HI = 6'h0F;
    localparam logic [ADDR_W-1:0] ADDR_CTRL    = 6'h10;
    localparam logic [ADDR_W-1:0] ADDR_CNT1_LO = 6'h14;
    localparam logic [ADDR_W-1:0] ADDR_CNT1_HI = 6'h15;
    localparam logic [ADDR_W-1:0] ADDR_RLD1_LO = 6'h16;
    localparam logic [ADDR_W-1:0] ADDR_RLD1_HI = 6'h17;
    localparam logic [ADDR_W-1:0] ADDR_FREE    = 6'h18;

    localparam int CTL_EN0   = 0;
    localparam int CTL_IE0   = 4;
    localparam int CTL_FLAG0 = 6;

    localparam logic [DATA_W-1:0] CTL_WRITE_MASK = 8'h3F;
    localparam logic [DATA_W-1:0] UNMAPPED_DATA  = 8'hFF;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] reg_addr;
        logic [DATA_W-1:0] write_data;
        logic [CLK_W-1:0]  clock_count;
    } item_t;

    typedef struct packed {
        item_t            item;
        logic [CLK_W-1:0] quot;
    } div_item_t;

endpackage

>>> hdl/drt_front.sv
// Input register and constant-divide stage of the dual reload timer block.
// Depends on drt_pkg; feeds drt_core.
module drt_front
    import drt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  item_t     in_item,
    input  logic      take,
    output logic      div_valid,
    output div_item_t div_data
);

    localparam int PROD_W = CLK_W + DIV_SHIFT;

    logic      in_valid_reg;
    item_t     in_data_reg;
    logic      div_valid_reg;
    div_item_t div_data_reg;

    logic               div_adv;
    logic               in_adv;
    logic [PROD_W-1:0]  prod;
    div_item_t          div_data_next;

    assign div_adv  = !div_valid_reg || take;
    assign in_adv   = !in_valid_reg || div_adv;
    assign in_stall = !in_adv;

    // Clock count over the divisor by reciprocal multiply; the remainder follows later.
    always_comb
    begin
        prod = PROD_W'(in_data_reg.clock_count) * PROD_W'(DIV_MULT);
        div_data_next.item = in_data_reg;
        div_data_next.quot = CLK_W'(prod >> DIV_SHIFT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            div_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_adv)
            begin
                in_valid_reg <= in_valid;
            end
            if (div_adv)
            begin
                div_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_adv && in_valid)
        begin
            in_data_reg <= in_item;
        end
        if (div_adv && in_valid_reg)
        begin
            div_data_reg <= div_data_next;
        end
    end

    assign div_valid = div_valid_reg;
    assign div_data  = div_data_reg;

endmodule

>>> hdl/drt_core.sv
// Timer state, register access, prescaler and result register of the timer block.
// Depends on drt_pkg; takes divided items from drt_front.
module drt_core
    import drt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              div_valid,
    input  div_item_t         div_data,
    output logic              take,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DATA_W-1:0] read_data,
    output logic              timer0_irq,
    output logic              timer1_irq
);

    logic [1:0][CNT_W-1:0]  count_reg;
    logic [1:0][CNT_W-1:0]  count_next;
    logic [1:0][CNT_W-1:0]  reload_reg;
    logic [1:0][CNT_W-1:0]  reload_next;
    logic [1:0][DATA_W-1:0] latch_reg;
    logic [1:0][DATA_W-1:0] latch_next;
    logic [DATA_W-1:0]      ctl_reg;
    logic [DATA_W-1:0]      ctl_next;
    logic [FREE_W-1:0]      free_reg;
    logic [FREE_W-1:0]      free_next;
    logic [REM_W-1:0]       rem_reg;
    logic [REM_W-1:0]       rem_next;

    logic              out_valid_reg;
    logic [DATA_W-1:0] read_data_reg;
    logic [DATA_W-1:0] read_data_next;
    logic              irq0_reg;
    logic              irq1_reg;

    logic              fire;
    logic              idx;
    logic [CLK_W-1:0]  quot_scaled;
    logic [CLK_W-1:0]  rem_full;
    logic [REM_W-1:0]  rem_in;
    logic [REM_W:0]    rem_sum;
    logic              carry;
    logic [REM_W-1:0]  rem_left;
    logic [CLK_W-1:0]  ticks;
    logic              prescale_fire;

    assign take = !out_valid_reg || !out_stall;
    assign fire = div_valid && take;
    assign idx  = (div_data.item.reg_addr >= ADDR_CNT1_LO);

    // Remainder of the clock count, then fold in what the prescaler already holds.
    always_comb
    begin
        quot_scaled = CLK_W'(div_data.quot * CLK_W'(PRESCALE_DIVISOR));
        rem_full    = div_data.item.clock_count - quot_scaled;
        rem_in      = REM_W'(rem_full);
        rem_sum     = (REM_W + 1)'(rem_reg) + (REM_W + 1)'(rem_in);
        carry       = (rem_sum >= (REM_W + 1)'(PRESCALE_DIVISOR));
        rem_left    = carry ? REM_W'(rem_sum - (REM_W + 1)'(PRESCALE_DIVISOR))
                            : REM_W'(rem_sum);
        ticks       = div_data.quot + CLK_W'(carry);
        // Exactly the divisor accumulated does not fire.
        prescale_fire = (ticks >= CLK_W'(2)) ||
                        ((ticks == CLK_W'(1)) && (rem_left != '0));
    end

    always_comb
    begin
        count_next     = count_reg;
        reload_next    = reload_reg;
        latch_next     = latch_reg;
        ctl_next       = ctl_reg;
        free_next      = free_reg;
        rem_next       = rem_reg;
        read_data_next = '0;

        case (div_data.item.cmd)
            CMD_READ:
            begin
                case (div_data.item.reg_addr)
                    ADDR_CNT0_LO, ADDR_CNT1_LO:
                    begin
                        latch_next[idx] = count_reg[idx][CNT_W-1:DATA_W];
                        ctl_next[CTL_FLAG0 + int'(idx)] = 1'b0;
                        read_data_next = count_reg[idx][DATA_W-1:0];
                    end
                    ADDR_CNT0_HI, ADDR_CNT1_HI:
                    begin
                        ctl_next[CTL_FLAG0 + int'(idx)] = 1'b0;
                        read_data_next = latch_reg[idx];
                    end
                    ADDR_RLD0_LO, ADDR_RLD1_LO:
                    begin
                        read_data_next = reload_reg[idx][DATA_W-1:0];
                    end
                    ADDR_RLD0_HI, ADDR_RLD1_HI:
                    begin
                        read_data_next = reload_reg[idx][CNT_W-1:DATA_W];
                    end
                    ADDR_CTRL:
                    begin
                        read_data_next = ctl_reg;
                    end
                    ADDR_FREE:
                    begin
                        read_data_next = free_reg;
                    end
                    default:
                    begin
                        read_data_next = UNMAPPED_DATA;
                    end
                endcase
            end
            CMD_WRITE:
            begin
                case (div_data.item.reg_addr)
                    ADDR_CNT0_LO, ADDR_CNT1_LO:
                    begin
                        count_next[idx][DATA_W-1:0] = div_data.item.write_data;
                    end
                    ADDR_CNT0_HI, ADDR_CNT1_HI:
                    begin
                        count_next[idx][CNT_W-1:DATA_W] = div_data.item.write_data;
                    end
                    ADDR_RLD0_LO, ADDR_RLD1_LO:
                    begin
                        reload_next[idx][DATA_W-1:0] = div_data.item.write_data;
                    end
                    ADDR_RLD0_HI, ADDR_RLD1_HI:
                    begin
                        reload_next[idx][CNT_W-1:DATA_W] = div_data.item.write_data;
                    end
                    ADDR_CTRL:
                    begin
                        // The flag bits are read-only.
                        ctl_next = (ctl_reg & ~CTL_WRITE_MASK) |
                                   (div_data.item.write_data & CTL_WRITE_MASK);
                    end
                    default:
                    begin
                    end
                endcase
            end
            CMD_TICK:
            begin
                if (prescale_fire)
                begin
                    free_next = free_reg + ticks[FREE_W-1:0];
                    rem_next  = rem_left;
                    for (int i = 0; i < 2; i++)
                    begin
                        if (ctl_reg[CTL_EN0 + i])
                        begin
                            if (count_reg[i] > ticks)
                            begin
                                count_next[i] = count_reg[i] - ticks;
                            end
                            else
                            begin
                                // Reload less the overshoot, wrapping at 16 bits.
                                count_next[i] = reload_reg[i] - (ticks - count_reg[i]);
                                ctl_next[CTL_FLAG0 + i] = 1'b1;
                            end
                        end
                    end
                end
                else
                begin
                    // Without a fire the total is either below the divisor or exactly it.
                    rem_next = (ticks != '0) ? REM_W'(PRESCALE_DIVISOR) : rem_left;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            reload_reg    <= '0;
            latch_reg     <= '0;
            ctl_reg       <= '0;
            free_reg      <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                count_reg  <= count_next;
                reload_reg <= reload_next;
                latch_reg  <= latch_next;
                ctl_reg    <= ctl_next;
                free_reg   <= free_next;
                rem_reg    <= rem_next;
            end
            if (take)
            begin
                out_valid_reg <= div_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            read_data_reg <= read_data_next;
            irq0_reg      <= ctl_next[CTL_FLAG0] & ctl_next[CTL_IE0];
            irq1_reg      <= ctl_next[CTL_FLAG0 + 1] & ctl_next[CTL_IE0 + 1];
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_data  = read_data_reg;
    assign timer0_irq = irq0_reg;
    assign timer1_irq = irq1_reg;

endmodule

>>> hdl/dual_reload_timer_registers_top.sv
// Top level of the dual reload timer block: two 16-bit reload timers, control
// register and free-running counter behind byte registers. Uses drt_pkg, drt_front, drt_core.
//
// Usage:
// - Input channel (in_valid / in_stall) carries one item: a register read, a
//   register write or a clock tick with its clock count.
// - Output channel (out_valid / out_stall) returns exactly one result item per
//   input item, in order: the read byte (0xFF for unmapped offsets, 0 for writes
//   and ticks) and both timer interrupt requests as they stand after the item.
// - An accepted item passes through the input register, the constant-divide
//   register and the result register, in that order.
// - Throughput is one item per cycle unless stalled. The timer state is read and written in a
//   single cycle of the last stage, so consecutive items see each other's effects.
// - When the receiver stalls, the result register holds and the stages behind it
//   fill; in_stall rises once all three stages hold items.
// - Reset clears all timer state, the prescaler and the pipeline valid bits.
module dual_reload_timer_registers_top
    import drt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CMD_W-1:0]  cmd,
    input  logic [ADDR_W-1:0] reg_addr,
    input  logic [DATA_W-1:0] write_data,
    input  logic [CLK_W-1:0]  clock_count,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DATA_W-1:0] read_data,
    output logic              timer0_irq,
    output logic              timer1_irq
);

    item_t     in_item;
    logic      take;
    logic      div_valid;
    div_item_t div_data;

    assign in_item.cmd         = cmd;
    assign in_item.reg_addr    = reg_addr;
    assign in_item.write_data  = write_data;
    assign in_item.clock_count = clock_count;

    drt_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .take      (take),
        .div_valid (div_valid),
        .div_data  (div_data)
    );

    drt_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .div_valid  (div_valid),
        .div_data   (div_data),
        .take       (take),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_data  (read_data),
        .timer0_irq (timer0_irq),
        .timer1_irq (timer1_irq)
    );

endmodule

>>> hdl/drt_checker.sv
// Port-level checker for the dual reload timer top level, bound to it below.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module drt_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [1:0] cmd,
    input logic [5:0] reg_addr,
    input logic [7:0] write_data,
    input logic [15:0] clock_count,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] read_data,
    input logic       timer0_irq,
    input logic       timer1_irq
);

    logic unused_inputs;
    assign unused_inputs = in_valid ^ (^cmd) ^ (^reg_addr) ^ (^write_data) ^ (^clock_count);

    // A stalled result stays offered.
    `DRT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

    // A stalled result keeps its payload.
    `DRT_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(read_data) && $stable(timer0_irq) && $stable(timer1_irq))

    // Input back-pressure only arises from a full, stalled result register.
    `DRT_ASSERT_IMP(a_backpressure, clk, rst_n, in_stall, out_valid && out_stall)

endmodule

bind dual_reload_timer_registers_top drt_checker u_drt_checker (.*);
